@@ hdl/sip_via_sentby_scanner_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the Via sent-by scanner
// Shorthand for clocked implications with an asynchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef SIP_VIA_SENTBY_SCANNER_MACROS_SVH
`define SIP_VIA_SENTBY_SCANNER_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define SVS_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define SVS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/svs_pkg.sv @@
// ----------------------------------------------------------------------------
// Via sent-by scanner package
// Shared types, constants, character classes and the scanner transition table.
// ----------------------------------------------------------------------------
`default_nettype none

package svs_pkg;

	// Scan length limit and the widths that follow from it.
	localparam int MAX_LEN = 1024;
	localparam int POS_W   = $clog2(MAX_LEN + 1);
	localparam int MARK_W  = $clog2(MAX_LEN);

	// Fixed field widths of the result.
	localparam int START_W  = 10;
	localparam int LEN_W    = 11;
	localparam int STATUS_W = 3;
	localparam int NFIELD   = 5;

	// Field slots.
	localparam int F_PROTO = 0;
	localparam int F_VER   = 1;
	localparam int F_TR    = 2;
	localparam int F_HOST  = 3;
	localparam int F_PORT  = 4;

	// Queue sizing shared by the front queue and the result queue.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Configuration port.
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_BASE_OFFSET = 1'b0;

	// Characters with a role of their own.
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_GRAVE  = 8'h60;
	localparam logic [7:0] CH_TILDE  = 8'h7E;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UF     = 8'h46;
	localparam logic [7:0] CH_UZ     = 8'h5A;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LF_HEX = 8'h66;
	localparam logic [7:0] CH_LZ     = 8'h7A;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		STAT_RUNNING    = 3'd0,
		STAT_SEMI       = 3'd1,
		STAT_OK         = 3'd2,
		STAT_BAD        = 3'd3,
		STAT_INCOMPLETE = 3'd4,
		STAT_TOO_LONG   = 3'd5
	} status_t;

	// Scanner states.
	typedef enum logic [4:0] {
		SS_SPACES,
		SS_PNAME,
		SS_PNAME_LWS,
		SS_VER_START,
		SS_VER_START_LWS,
		SS_VER,
		SS_VER_LWS,
		SS_TR_START,
		SS_TR_START_LWS,
		SS_TR,
		SS_TR_LWS,
		SS_HOST,
		SS_HOST_LWS,
		SS_V6_START,
		SS_V6,
		SS_V6_END,
		SS_V6_END_LWS,
		SS_PORT_START,
		SS_PORT_START_LWS,
		SS_PORT,
		SS_PORT_LWS,
		SS_SEMI,
		SS_DEAD
	} scan_state_t;

	// Input beat.
	typedef struct packed {
		logic [7:0] byte_in;
		logic       last_byte;
	} item_t;

	// Result beat.
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [START_W-1:0]  protocol_start;
		logic [LEN_W-1:0]    protocol_len;
		logic [START_W-1:0]  version_start;
		logic [LEN_W-1:0]    version_len;
		logic [START_W-1:0]  transport_start;
		logic [LEN_W-1:0]    transport_len;
		logic [START_W-1:0]  host_start;
		logic [LEN_W-1:0]    host_len;
		logic [START_W-1:0]  port_start;
		logic [LEN_W-1:0]    port_len;
	} result_t;

	// Character classes of one byte.
	typedef struct packed {
		logic token;
		logic host;
		logic v6;
		logic digit;
		logic lws;
		logic slash;
		logic colon;
		logic semi;
		logic lbrack;
		logic rbrack;
	} cls_t;

	// Entry of the queue between the front and the back.
	typedef struct packed {
		cls_t cls;
		logic last;
	} fq_entry_t;

	// Head of that queue as the back sees it.
	typedef struct packed {
		logic      valid;
		fq_entry_t ent;
	} fq_head_t;

	// Sort one byte into its character classes.
	function automatic cls_t classify(logic [7:0] c);
		cls_t r;
		logic is_num;
		logic is_alpha;
		logic is_hexl;
		is_num   = (c >= CH_0) && (c <= CH_9);
		is_alpha = ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ));
		is_hexl  = ((c >= CH_LA) && (c <= CH_LF_HEX)) || ((c >= CH_UA) && (c <= CH_UF));
		r.digit  = is_num;
		r.host   = is_num || is_alpha || (c == CH_DASH) || (c == CH_DOT);
		r.token  = r.host || (c == CH_BANG) || (c == CH_PCT) || (c == CH_STAR) ||
			(c == CH_UNDER) || (c == CH_PLUS) || (c == CH_GRAVE) ||
			(c == CH_QUOTE) || (c == CH_TILDE);
		r.v6     = is_num || is_hexl || (c == CH_COLON) || (c == CH_DOT);
		r.lws    = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
		r.slash  = (c == CH_SLASH);
		r.colon  = (c == CH_COLON);
		r.semi   = (c == CH_SEMI);
		r.lbrack = (c == CH_LBRACK);
		r.rbrack = (c == CH_RBRACK);
		return r;
	endfunction

	// Transition table of the scanner; a byte that no arm accepts leads to SS_DEAD.
	function automatic scan_state_t next_state(scan_state_t s, cls_t c);
		scan_state_t n;
		n = SS_DEAD;
		unique case (s) inside
			SS_SPACES: begin
				if (c.token) n = SS_PNAME;
				else if (c.lws) n = SS_SPACES;
			end
			SS_PNAME: begin
				if (c.token) n = SS_PNAME;
				else if (c.slash) n = SS_VER_START;
				else if (c.lws) n = SS_PNAME_LWS;
			end
			SS_PNAME_LWS: begin
				if (c.lws) n = SS_PNAME_LWS;
				else if (c.slash) n = SS_VER_START;
			end
			SS_VER_START, SS_VER_START_LWS: begin
				if (c.token) n = SS_VER;
				else if (c.lws) n = SS_VER_START_LWS;
			end
			SS_VER: begin
				if (c.token) n = SS_VER;
				else if (c.lws) n = SS_VER_LWS;
				else if (c.slash) n = SS_TR_START;
			end
			SS_VER_LWS: begin
				if (c.lws) n = SS_VER_LWS;
				else if (c.slash) n = SS_TR_START;
			end
			SS_TR_START, SS_TR_START_LWS: begin
				if (c.token) n = SS_TR;
				else if (c.lws) n = SS_TR_START_LWS;
			end
			SS_TR: begin
				if (c.token) n = SS_TR;
				else if (c.lws) n = SS_TR_LWS;
			end
			SS_TR_LWS: begin
				if (c.lws) n = SS_TR_LWS;
				else if (c.host) n = SS_HOST;
				else if (c.lbrack) n = SS_V6_START;
			end
			SS_HOST: begin
				if (c.host) n = SS_HOST;
				else if (c.colon) n = SS_PORT_START;
				else if (c.lws) n = SS_HOST_LWS;
				else if (c.semi) n = SS_SEMI;
			end
			SS_HOST_LWS, SS_V6_END_LWS: begin
				if (c.lws) n = s;
				else if (c.colon) n = SS_PORT_START;
			end
			SS_V6_START: begin
				if (c.v6) n = SS_V6;
			end
			SS_V6: begin
				if (c.v6) n = SS_V6;
				else if (c.rbrack) n = SS_V6_END;
			end
			SS_V6_END: begin
				if (c.lws) n = SS_V6_END_LWS;
				else if (c.colon) n = SS_PORT_START;
				else if (c.semi) n = SS_SEMI;
			end
			SS_PORT_START, SS_PORT_START_LWS: begin
				if (c.digit) n = SS_PORT;
				else if (c.lws) n = SS_PORT_START_LWS;
			end
			SS_PORT: begin
				if (c.digit) n = SS_PORT;
				else if (c.lws) n = SS_PORT_LWS;
				else if (c.semi) n = SS_SEMI;
			end
			SS_PORT_LWS: begin
				if (c.lws) n = SS_PORT_LWS;
				else if (c.semi) n = SS_SEMI;
			end
			default: n = SS_DEAD;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

@@ hdl/svs_cfg.sv @@
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style slave holding the base offset added to every field start.
// ----------------------------------------------------------------------------
`default_nettype none

module svs_cfg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [svs_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [svs_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [svs_pkg::APB_DATA_W-1:0] prdata,
	output logic                                pready,
	output logic      [svs_pkg::START_W-1:0]    base_offset
);
	import svs_pkg::*;

	logic                 wr_en;
	logic [START_W-1:0]   base_offset_q;

	// The register is selected by the top address bit.
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready &&
		(paddr[APB_ADDR_W-1] == REG_BASE_OFFSET);

	// Base offset register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_offset_q <= '0;
		end else if (wr_en) begin
			base_offset_q <= pwdata[START_W-1:0];
		end
	end

	// Read data: the base offset when the top address bit selects it, zero elsewhere.
	always_comb begin
		prdata = '0;
		if (paddr[APB_ADDR_W-1] == REG_BASE_OFFSET) begin
			prdata = {{(APB_DATA_W-START_W){1'b0}}, base_offset_q};
		end
	end

	assign base_offset = base_offset_q;

endmodule

`default_nettype wire

@@ hdl/svs_front.sv @@
// ----------------------------------------------------------------------------
// Scanner front end
// Accepts input beats, sorts each byte into character classes and queues it.
// ----------------------------------------------------------------------------
`default_nettype none

module svs_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire svs_pkg::item_t   item,
	output logic                  full,
	input  wire logic             take,
	output svs_pkg::fq_head_t     head
);
	import svs_pkg::*;

	fq_entry_t           ent_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_q;
	logic [QPTR_W-1:0]   rd_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic                wr_en;
	logic                rd_en;

	assign full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign wr_en = push && !full;
	assign rd_en = take && (cnt_q != '0);

	// Queue storage: classified byte plus its end-of-buffer flag.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			ent_q[wr_q].cls  <= classify(item.byte_in);
			ent_q[wr_q].last <= item.last_byte;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (rd_en) begin
				rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Oldest queued byte.
	assign head.valid = (cnt_q != '0);
	assign head.ent   = ent_q[rd_q];

endmodule

`default_nettype wire

@@ hdl/svs_back.sv @@
// ----------------------------------------------------------------------------
// Scanner back end
// Runs the Via state machine one byte per cycle while a byte is queued and the result queue has room.
// ----------------------------------------------------------------------------
`default_nettype none

module svs_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [svs_pkg::START_W-1:0] base_offset,
	input  wire svs_pkg::fq_head_t           head,
	output logic                             take,
	input  wire logic                        res_full,
	output svs_pkg::result_t                 res
);
	import svs_pkg::*;

	scan_state_t          state_q;
	scan_state_t          ns;
	logic [POS_W-1:0]     pos_q;
	logic [MARK_W-1:0]    marks_q  [NFIELD];
	logic [START_W-1:0]   starts_q [NFIELD];
	logic [LEN_W-1:0]     lens_q   [NFIELD];

	logic [POS_W-1:0]     idx_next;
	logic                 too_long;
	status_t              status_n;
	logic [NFIELD-1:0]    mark_en;
	logic [NFIELD-1:0]    rec_en;
	logic [POS_W-1:0]     rec_end  [NFIELD];
	logic [MARK_W-1:0]    mark_n   [NFIELD];
	logic [START_W-1:0]   start_n  [NFIELD];
	logic [LEN_W-1:0]     len_n    [NFIELD];
	logic [START_W-1:0]   start_sum[NFIELD];
	logic [POS_W-1:0]     len_diff [NFIELD];

	// A byte is taken whenever one is queued and the result queue has room.
	assign take = head.valid && !res_full;

	// Next state of the scanner.
	always_comb begin : next_state_logic
		ns = next_state(state_q, head.ent.cls);
	end

	// Field marks, field records and the status of this byte.
	always_comb begin : step_logic
		idx_next = pos_q + POS_W'(1);
		too_long = (pos_q >= POS_W'(MAX_LEN));
		mark_en  = '0;
		rec_en   = '0;
		for (int f = 0; f < NFIELD; f++) begin
			rec_end[f] = pos_q;
		end

		// Opening and closing of fields on each transition.
		case (ns) inside
			SS_PNAME: begin
				if (state_q == SS_SPACES) mark_en[F_PROTO] = 1'b1;
			end
			SS_PNAME_LWS, SS_VER_START: begin
				if (state_q == SS_PNAME) rec_en[F_PROTO] = 1'b1;
			end
			SS_VER: begin
				if (state_q inside {SS_VER_START, SS_VER_START_LWS}) mark_en[F_VER] = 1'b1;
			end
			SS_VER_LWS, SS_TR_START: begin
				if (state_q == SS_VER) rec_en[F_VER] = 1'b1;
			end
			SS_TR: begin
				if (state_q inside {SS_TR_START, SS_TR_START_LWS}) mark_en[F_TR] = 1'b1;
			end
			SS_TR_LWS: begin
				if (state_q == SS_TR) rec_en[F_TR] = 1'b1;
			end
			SS_HOST, SS_V6_START: begin
				if (state_q == SS_TR_LWS) mark_en[F_HOST] = 1'b1;
			end
			SS_HOST_LWS: begin
				if (state_q == SS_HOST) rec_en[F_HOST] = 1'b1;
			end
			SS_V6_END_LWS: begin
				if (state_q == SS_V6_END) rec_en[F_HOST] = 1'b1;
			end
			SS_PORT_START: begin
				if (state_q inside {SS_HOST, SS_V6_END}) rec_en[F_HOST] = 1'b1;
			end
			SS_PORT: begin
				if (state_q inside {SS_PORT_START, SS_PORT_START_LWS}) mark_en[F_PORT] = 1'b1;
			end
			SS_PORT_LWS: begin
				if (state_q == SS_PORT) rec_en[F_PORT] = 1'b1;
			end
			SS_SEMI: begin
				if (state_q inside {SS_HOST, SS_V6_END}) rec_en[F_HOST] = 1'b1;
				else if (state_q == SS_PORT) rec_en[F_PORT] = 1'b1;
			end
			default: begin
			end
		endcase

		// Status; on the last byte an open host or port is closed after it.
		if (too_long) begin
			status_n = STAT_TOO_LONG;
			mark_en  = '0;
			rec_en   = '0;
		end else if (ns == SS_DEAD) begin
			status_n = STAT_BAD;
		end else if (ns == SS_SEMI) begin
			status_n = STAT_SEMI;
		end else if (head.ent.last) begin
			if (ns == SS_HOST || ns == SS_V6_END) begin
				rec_en[F_HOST]  = 1'b1;
				rec_end[F_HOST] = idx_next;
				status_n        = STAT_OK;
			end else if (ns == SS_PORT) begin
				rec_en[F_PORT]  = 1'b1;
				rec_end[F_PORT] = idx_next;
				status_n        = STAT_OK;
			end else if (ns == SS_HOST_LWS || ns == SS_V6_END_LWS || ns == SS_PORT_LWS) begin
				status_n = STAT_OK;
			end else begin
				status_n = STAT_INCOMPLETE;
			end
		end else begin
			status_n = STAT_RUNNING;
		end

		// Updated marks, starts and lengths; a record sees a mark set by the same byte.
		for (int f = 0; f < NFIELD; f++) begin
			mark_n[f]    = mark_en[f] ? pos_q[MARK_W-1:0] : marks_q[f];
			start_sum[f] = base_offset + START_W'(mark_n[f]);
			len_diff[f]  = rec_end[f] - POS_W'(mark_n[f]);
			start_n[f]   = rec_en[f] ? start_sum[f] : starts_q[f];
			len_n[f]     = rec_en[f] ? LEN_W'(len_diff[f]) : lens_q[f];
		end
	end

	// Result beat for this byte.
	always_comb begin : result_logic
		res.status          = status_n;
		res.protocol_start  = start_n[F_PROTO];
		res.protocol_len    = len_n[F_PROTO];
		res.version_start   = start_n[F_VER];
		res.version_len     = len_n[F_VER];
		res.transport_start = start_n[F_TR];
		res.transport_len   = len_n[F_TR];
		res.host_start      = start_n[F_HOST];
		res.host_len        = len_n[F_HOST];
		res.port_start      = start_n[F_PORT];
		res.port_len        = len_n[F_PORT];
	end

	// Scan state; a finished scan returns everything to its reset value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SS_SPACES;
			pos_q   <= '0;
			for (int f = 0; f < NFIELD; f++) begin
				marks_q[f]  <= '0;
				starts_q[f] <= '0;
				lens_q[f]   <= '0;
			end
		end else if (take) begin
			if (status_n == STAT_RUNNING) begin
				state_q <= ns;
				pos_q   <= idx_next;
				for (int f = 0; f < NFIELD; f++) begin
					marks_q[f]  <= mark_n[f];
					starts_q[f] <= start_n[f];
					lens_q[f]   <= len_n[f];
				end
			end else begin
				state_q <= SS_SPACES;
				pos_q   <= '0;
				for (int f = 0; f < NFIELD; f++) begin
					marks_q[f]  <= '0;
					starts_q[f] <= '0;
					lens_q[f]   <= '0;
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/svs_outq.sv @@
// ----------------------------------------------------------------------------
// Result queue
// Holds finished result beats until the consumer pops them.
// ----------------------------------------------------------------------------
`default_nettype none

module svs_outq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr,
	input  wire svs_pkg::result_t  din,
	output logic                   full,
	input  wire logic              pop,
	output logic                   empty,
	output svs_pkg::result_t       dout
);
	import svs_pkg::*;

	result_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_q;
	logic [QPTR_W-1:0]   rd_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic                wr_en;
	logic                rd_en;

	assign full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign wr_en = wr && !full;
	assign rd_en = pop && !empty;

	// Result storage.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_q] <= din;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (rd_en) begin
				rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign dout = mem_q[rd_q];

endmodule

`default_nettype wire

@@ hdl/sip_via_sentby_scanner.sv @@
// Path: an accepted byte is classified and registered in the front queue; the back end then
// scans it and its result beat is registered in the result queue when that queue has room,
// at which point empty falls and the result can be popped.
// Throughput: one byte per cycle while the result queue has room, set by the state update of the back end.
// Reset: asynchronous, active low; both queues empty, scanner in its before-value
// state with all field records zero, base offset zero. No clearing pass follows.
// ----------------------------------------------------------------------------
// Via sent-by scanner
// Front end classifies bytes into a short queue; back end scans them into results.
// ----------------------------------------------------------------------------
`default_nettype none

module sip_via_sentby_scanner (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	output logic                                full,
	input  wire svs_pkg::item_t                 item,
	output logic                                empty,
	input  wire logic                           pop,
	output svs_pkg::result_t                    result,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [svs_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [svs_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [svs_pkg::APB_DATA_W-1:0] prdata,
	output logic                                pready
);
	import svs_pkg::*;

	logic [START_W-1:0] base_offset;
	fq_head_t           head;
	logic               take;
	logic               res_full;
	result_t            res;

	// Configuration registers.
	svs_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.base_offset (base_offset)
	);

	// Front end: accept and classify.
	svs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.item   (item),
		.full   (full),
		.take   (take),
		.head   (head)
	);

	// Back end: state machine and field tracking.
	svs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.base_offset (base_offset),
		.head        (head),
		.take        (take),
		.res_full    (res_full),
		.res         (res)
	);

	// Result queue toward the consumer.
	svs_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (take),
		.din    (res),
		.full   (res_full),
		.pop    (pop),
		.empty  (empty),
		.dout   (result)
	);

endmodule

`default_nettype wire

@@ hdl/svs_checker.sv @@
// ----------------------------------------------------------------------------
// Scanner port checker
// Watches the top-level ports for result ordering and scan restart rules.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sip_via_sentby_scanner_macros.svh"

module svs_checker (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             empty,
	input  wire logic             pop,
	input  wire svs_pkg::result_t result
);
	import svs_pkg::*;

	logic ended_q;

	// Set when the last popped beat closed a scan, so the next one opens a new scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ended_q <= 1'b1;
		end else if (pop && !empty) begin
			ended_q <= (result.status != STAT_RUNNING);
		end
	end

	// Only defined status codes appear.
	`SVS_ASSERT_IMPLIES(a_status_range, clk, arst_n, !empty, result.status <= STAT_TOO_LONG, "undefined status code")

	// A waiting result stays in place until popped.
	`SVS_ASSERT_NEXT(a_result_hold, clk, arst_n, !empty && !pop, !empty && $stable(result), "waiting result changed")

	// The first byte of a scan cannot have closed any field.
	`SVS_ASSERT_IMPLIES(a_fresh_scan, clk, arst_n, !empty && ended_q, (result.protocol_len == '0) && (result.version_len == '0) && (result.transport_len == '0) && (result.host_len == '0) && (result.port_len == '0), "stale field on new scan")

endmodule

bind sip_via_sentby_scanner svs_checker u_svs_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);

`default_nettype wire
